// File: sv/sts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the selection text serializer.
package sts_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 65536;
  localparam int unsigned PENDING_LIMIT = 1024;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned NUM_SLOTS = 6;

  localparam logic [2:0] SLOT_FLUSH = 3'd0;
  localparam logic [2:0] SLOT_LEAD = 3'd1;
  localparam logic [2:0] SLOT_LINE = 3'd5;

  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_NONE = 8'h00;

  typedef enum logic [2:0] {
    REG_ACTIVE    = 3'd0,
    REG_FIRST_ROW = 3'd1,
    REG_FIRST_COL = 3'd2,
    REG_LAST_ROW  = 3'd3,
    REG_LAST_COL  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        active;
    logic [15:0] first_row;
    logic [9:0]  first_column;
    logic [15:0] last_row;
    logic [9:0]  last_column;
  } sel_cfg_t;

  typedef struct packed {
    logic [10:0]          flush_count;
    logic [3:0][7:0]      utf8;
    logic [NUM_SLOTS-1:0] slots;
    logic                 text_final;
  } cmd_t;

endpackage

// File: sv/selection_text_serializer_top.sv
`timescale 1ns / 1ps
// Top level of the selection text serializer: configuration registers and wiring.
//
//   Channel  Handshake                 Payload
//   ------   ------------------------  ----------------------------------------------
//   cells    push / full               row_index_i .. no_cell_i
//   text     empty / pop               out_byte_o, repeat_count_o, text_end_o
//   config   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A cell is taken in every cycle in which the two-entry command queue has room.
// The result sequencer sends one beat per cycle unless a stalled pop holds it, and
// a cell causes up to six beats, stepped out by the back end.
// A cell's first beat passes the queue entry, command register and output register.
// Reset clears the selection registers, the held space count, the queue and the
// output valid flag. A stalled pop holds the output beat and backs up into full.
module selection_text_serializer_top #(
  parameter int unsigned MAX_COLUMNS = sts_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS = sts_pkg::MAX_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] row_index_i,
  input  logic [9:0]  column_index_i,
  input  logic [10:0] line_width_i,
  input  logic [20:0] glyph_code_i,
  input  logic        wide_half_i,
  input  logic        row_wrapped_i,
  input  logic        row_end_i,
  input  logic        no_cell_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [10:0] repeat_count_o,
  output logic        text_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sts_pkg::*;

  sel_cfg_t cfg_q;
  cmd_t     front_cmd, head_cmd;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;

  assign cfg_ready_o = 1'b1;
  assign full = cmd_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ACTIVE:    cfg_q.active <= cfg_data_i[0];
        REG_FIRST_ROW: cfg_q.first_row <= cfg_data_i;
        REG_FIRST_COL: cfg_q.first_column <= cfg_data_i[9:0];
        REG_LAST_ROW:  cfg_q.last_row <= cfg_data_i;
        REG_LAST_COL:  cfg_q.last_column <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  sts_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (push),
    .row_index_i   (row_index_i),
    .column_index_i(column_index_i),
    .line_width_i  (line_width_i),
    .glyph_code_i  (glyph_code_i),
    .wide_half_i   (wide_half_i),
    .row_wrapped_i (row_wrapped_i),
    .row_end_i     (row_end_i),
    .no_cell_i     (no_cell_i),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (front_cmd)
  );

  sts_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (front_cmd),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (head_cmd)
  );

  sts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (cmd_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_byte_o    (out_byte_o),
    .repeat_count_o(repeat_count_o),
    .text_end_o    (text_end_o)
  );

  // The front end never offers a command to a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_push && cmd_full))
    else $error("command pushed into a full queue");

  // The sequencer never takes a command from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_pop && cmd_empty))
    else $error("command taken from an empty queue");

  // A zero count appears only on the empty end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && repeat_count_o == 11'd0) |-> (text_end_o && out_byte_o == BYTE_NONE))
    else $error("zero repeat count outside the end marker");

  // Only held spaces are sent with a repeat count above one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && repeat_count_o > 11'd1) |-> (out_byte_o == BYTE_SPACE))
    else $error("repeated beat that is not a space");

endmodule

// File: sv/sts_front.sv
`timescale 1ns / 1ps
// Front end: selects cells, tracks held spaces and encodes UTF-8 into commands.
module sts_front #(
  parameter int unsigned MAX_COLUMNS = sts_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS = sts_pkg::MAX_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sts_pkg::sel_cfg_t cfg_i,
  input  logic              item_valid_i,
  input  logic [15:0]       row_index_i,
  input  logic [9:0]        column_index_i,
  input  logic [10:0]       line_width_i,
  input  logic [20:0]       glyph_code_i,
  input  logic              wide_half_i,
  input  logic              row_wrapped_i,
  input  logic              row_end_i,
  input  logic              no_cell_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output sts_pkg::cmd_t     cmd_o
);
  import sts_pkg::*;

  logic [10:0] pending_q, pending_d, pending_inc, pending_mid;
  logic        accept, in_rows, is_first, is_last, kept, is_space;
  logic        kept_char, kept_space, at_line_end, newline, text_final;
  logic [10:0] flush;
  logic [3:0]  utf8_mask;
  logic [3:0][7:0] utf8;

  assign accept = item_valid_i && !cmd_full_i;
  assign is_first = (row_index_i == cfg_i.first_row);
  assign is_last = (row_index_i == cfg_i.last_row);
  assign in_rows = cfg_i.active && (row_index_i >= cfg_i.first_row) &&
                   (row_index_i <= cfg_i.last_row) && (32'(row_index_i) < MAX_ROWS);

  assign kept = !no_cell_i && !wide_half_i &&
                (!is_first || (column_index_i >= cfg_i.first_column)) &&
                ({1'b0, column_index_i} < line_width_i) &&
                (32'(column_index_i) < MAX_COLUMNS) &&
                (!is_last || (column_index_i <= cfg_i.last_column));
  assign is_space = (glyph_code_i == 21'd0) || (glyph_code_i == 21'(BYTE_SPACE));
  assign kept_char = kept && !is_space;
  assign kept_space = kept && is_space;

  assign at_line_end = !(is_last &&
                         (32'(cfg_i.last_column) + 32'd1 < 32'(line_width_i)) &&
                         (32'(cfg_i.last_column) + 32'd1 < MAX_COLUMNS));

  assign pending_inc = (pending_q < 11'(PENDING_LIMIT)) ? pending_q + 11'd1 : pending_q;
  assign pending_mid = kept_char ? 11'd0 : (kept_space ? pending_inc : pending_q);

  always_comb begin
    if (kept_char) begin
      flush = pending_q;
    end else if (row_end_i && !at_line_end) begin
      flush = pending_mid;
    end else begin
      flush = 11'd0;
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (accept && in_rows) begin
      pending_d = row_end_i ? 11'd0 : pending_mid;
    end
  end

  assign newline = row_end_i && !is_last && !row_wrapped_i;
  assign text_final = row_end_i && is_last;

  assign utf8_mask = {glyph_code_i >= 21'h10000, glyph_code_i >= 21'h800,
                      glyph_code_i >= 21'h80, 1'b1};

  always_comb begin
    utf8 = '0;
    if (glyph_code_i < 21'h80) begin
      utf8[0] = glyph_code_i[7:0];
    end else if (glyph_code_i < 21'h800) begin
      utf8[0] = 8'hC0 | {3'b000, glyph_code_i[10:6]};
      utf8[1] = 8'h80 | {2'b00, glyph_code_i[5:0]};
    end else if (glyph_code_i < 21'h10000) begin
      utf8[0] = 8'hE0 | {4'b0000, glyph_code_i[15:12]};
      utf8[1] = 8'h80 | {2'b00, glyph_code_i[11:6]};
      utf8[2] = 8'h80 | {2'b00, glyph_code_i[5:0]};
    end else begin
      utf8[0] = 8'hF0 | {5'b00000, glyph_code_i[20:18]};
      utf8[1] = 8'h80 | {2'b00, glyph_code_i[17:12]};
      utf8[2] = 8'h80 | {2'b00, glyph_code_i[11:6]};
      utf8[3] = 8'h80 | {2'b00, glyph_code_i[5:0]};
    end
  end

  always_comb begin
    cmd_o.flush_count = flush;
    cmd_o.utf8 = utf8;
    cmd_o.text_final = text_final;
    cmd_o.slots[SLOT_FLUSH] = (flush != 11'd0);
    cmd_o.slots[4:1] = kept_char ? utf8_mask : 4'b0000;
    cmd_o.slots[SLOT_LINE] = newline || (text_final && (flush == 11'd0) && !kept_char);
  end

  assign cmd_push_o = accept && in_rows && (cmd_o.slots != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 11'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

// File: sv/sts_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the result sequencer.
module sts_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sts_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sts_pkg::cmd_t data_o
);
  import sts_pkg::*;

  localparam int unsigned AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

  cmd_t          entries_q [CMD_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o = (count_q == CW'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// File: sv/sts_back.sv
`timescale 1ns / 1ps
// Back end: steps through the result slots of each command into an output register.
module sts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  sts_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    out_byte_o,
  output logic [10:0]   repeat_count_o,
  output logic          text_end_o
);
  import sts_pkg::*;

  cmd_t                 cmd_q;
  logic [NUM_SLOTS-1:0] mask_q, rest;
  logic [2:0]           idx;
  logic                 found, out_valid_q, advance, load;
  logic [7:0]           byte_d;
  logic [10:0]          count_d;

  always_comb begin
    idx = SLOT_FLUSH;
    found = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (mask_q[k] && !found) begin
        idx = 3'(k);
        found = 1'b1;
      end
    end
  end

  assign rest = mask_q & ~(NUM_SLOTS'(1) << idx);

  always_comb begin
    case (idx)
      SLOT_FLUSH: begin
        byte_d = BYTE_SPACE;
        count_d = cmd_q.flush_count;
      end
      SLOT_LINE: begin
        byte_d = cmd_q.text_final ? BYTE_NONE : BYTE_NEWLINE;
        count_d = cmd_q.text_final ? 11'd0 : 11'd1;
      end
      default: begin
        byte_d = cmd_q.utf8[2'(idx - SLOT_LEAD)];
        count_d = 11'd1;
      end
    endcase
  end

  assign advance = (mask_q != '0) && (!out_valid_q || pop_i);
  assign load = ((mask_q == '0) || (advance && (rest == '0))) && !cmd_empty_i;
  assign cmd_pop_o = load;
  assign empty_o = !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (advance) begin
      out_byte_o <= byte_d;
      repeat_count_o <= count_d;
      text_end_o <= cmd_q.text_final && (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        mask_q <= cmd_i.slots;
      end else if (advance) begin
        mask_q <= rest;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: test/selection_text_checker.sv
`timescale 1ns / 1ps
// Beat checker for the selection text serializer: predicts text beats per cell and compares them.
module selection_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [15:0] row_index_i,
  input  logic [9:0]  column_index_i,
  input  logic [10:0] line_width_i,
  input  logic [20:0] glyph_code_i,
  input  logic        wide_half_i,
  input  logic        row_wrapped_i,
  input  logic        row_end_i,
  input  logic        no_cell_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  out_byte_i,
  input  logic [10:0] repeat_count_i,
  input  logic        text_end_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned beats_due_o
);
  import sts_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic [10:0] copies;
    logic        is_end;
  } text_beat_t;

  sel_cfg_t    sel;
  text_beat_t  beats_due_q[$];
  text_beat_t  cell_beats[$];
  int unsigned held_spaces;
  int unsigned failures;

  function automatic void add_beat(input logic [7:0] b, input logic [10:0] n);
    text_beat_t beat;
    beat.text_byte = b;
    beat.copies = n;
    beat.is_end = 1'b0;
    cell_beats.insert(cell_beats.size(), beat);
  endfunction

  function automatic void flush_held();
    if (held_spaces != 0) begin
      add_beat(BYTE_SPACE, 11'(held_spaces));
      held_spaces = 0;
    end
  endfunction

  function automatic void encode_utf8(input logic [20:0] ch);
    if (ch < 21'h80) begin
      add_beat(ch[7:0], 11'd1);
    end else if (ch < 21'h800) begin
      add_beat(8'hC0 | 8'(ch[10:6]), 11'd1);
      add_beat(8'h80 | 8'(ch[5:0]), 11'd1);
    end else if (ch < 21'h10000) begin
      add_beat(8'hE0 | 8'(ch[15:12]), 11'd1);
      add_beat(8'h80 | 8'(ch[11:6]), 11'd1);
      add_beat(8'h80 | 8'(ch[5:0]), 11'd1);
    end else begin
      add_beat(8'hF0 | 8'(ch[20:18]), 11'd1);
      add_beat(8'h80 | 8'(ch[17:12]), 11'd1);
      add_beat(8'h80 | 8'(ch[11:6]), 11'd1);
      add_beat(8'h80 | 8'(ch[5:0]), 11'd1);
    end
  endfunction

  function automatic void predict_cell(input logic [15:0] row, input logic [9:0] col,
                                       input logic [10:0] wid, input logic [20:0] cp,
                                       input logic wide, input logic wrap,
                                       input logic rend, input logic nocell);
    int         width;
    int         from_col;
    int         to_col;
    logic [20:0] ch;
    text_beat_t  marker;
    cell_beats.delete();
    if (!sel.active || row < sel.first_row || row > sel.last_row) return;
    width = int'(wid);
    if (width > int'(MAX_COLUMNS_DEF)) width = int'(MAX_COLUMNS_DEF);
    from_col = (row == sel.first_row) ? int'(sel.first_column) : 0;
    to_col = width - 1;
    if (row == sel.last_row && int'(sel.last_column) < to_col) to_col = int'(sel.last_column);
    if (!nocell && !wide && int'(col) >= from_col && int'(col) <= to_col && int'(col) < width)
    begin
      ch = (cp == '0) ? 21'(BYTE_SPACE) : cp;
      if (ch == 21'(BYTE_SPACE)) begin
        if (held_spaces < PENDING_LIMIT) held_spaces++;
      end else begin
        flush_held();
        encode_utf8(ch);
      end
    end
    if (rend) begin
      if (to_col >= width - 1) held_spaces = 0;
      else flush_held();
      if (row != sel.last_row) begin
        if (!wrap) add_beat(BYTE_NEWLINE, 11'd1);
      end else if (cell_beats.size() > 0) begin
        cell_beats[cell_beats.size() - 1].is_end = 1'b1;
      end else begin
        marker.text_byte = BYTE_NONE;
        marker.copies = 11'd0;
        marker.is_end = 1'b1;
        cell_beats.insert(cell_beats.size(), marker);
      end
    end
    foreach (cell_beats[k]) beats_due_q.insert(beats_due_q.size(), cell_beats[k]);
  endfunction

  function automatic void check_beat();
    text_beat_t want;
    if (beats_due_q.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("unexpected beat: byte %h count %0d end %b", out_byte_i, repeat_count_i,
                 text_end_i);
    end else begin
      want = beats_due_q.pop_front();
      if (want.text_byte !== out_byte_i || want.copies !== repeat_count_i ||
          want.is_end !== text_end_i) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("beat mismatch: expected byte %h count %0d end %b, %s %h count %0d end %b",
                   want.text_byte, want.copies, want.is_end, "got byte",
                   out_byte_i, repeat_count_i, text_end_i);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel = '0;
      held_spaces = 0;
      failures = 0;
      beats_due_q.delete();
      fail_count_o <= 0;
      beats_due_o <= 0;
    end else begin
      if (pop_i && !empty_i) check_beat();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ACTIVE:    sel.active = cfg_data_i[0];
          REG_FIRST_ROW: sel.first_row = cfg_data_i;
          REG_FIRST_COL: sel.first_column = cfg_data_i[9:0];
          REG_LAST_ROW:  sel.last_row = cfg_data_i;
          REG_LAST_COL:  sel.last_column = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (push_i && !full_i)
        predict_cell(row_index_i, column_index_i, line_width_i, glyph_code_i, wide_half_i,
                     row_wrapped_i, row_end_i, no_cell_i);
      fail_count_o <= failures;
      beats_due_o <= beats_due_q.size();
    end
  end

endmodule

// File: test/selection_text_serializer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top of the selection text serializer: clock, reset, cell and config stimulus, verdict.
module selection_text_serializer_top_tb;
  import sts_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] row_index;
  logic [9:0]  column_index;
  logic [10:0] line_width;
  logic [20:0] glyph_code;
  logic        wide_half;
  logic        row_wrapped;
  logic        row_end;
  logic        no_cell;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic [10:0] repeat_count;
  logic        text_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int unsigned fail_count;
  int unsigned beats_due;
  int unsigned cells_sent;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_seq;
  int unsigned idle_cycles;
  logic        activity;

  assign activity = (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready);

  selection_text_serializer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .row_index_i    (row_index),
    .column_index_i (column_index),
    .line_width_i   (line_width),
    .glyph_code_i   (glyph_code),
    .wide_half_i    (wide_half),
    .row_wrapped_i  (row_wrapped),
    .row_end_i      (row_end),
    .no_cell_i      (no_cell),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte),
    .repeat_count_o (repeat_count),
    .text_end_o     (text_end),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  selection_text_checker text_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .row_index_i    (row_index),
    .column_index_i (column_index),
    .line_width_i   (line_width),
    .glyph_code_i   (glyph_code),
    .wide_half_i    (wide_half),
    .row_wrapped_i  (row_wrapped),
    .row_end_i      (row_end),
    .no_cell_i      (no_cell),
    .empty_i        (empty),
    .pop_i          (pop),
    .out_byte_i     (out_byte),
    .repeat_count_i (repeat_count),
    .text_end_i     (text_end),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .beats_due_o    (beats_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver counts a requested hold-off down by itself.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (activity) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("selection_text_serializer_top_tb failed");
    $finish;
  end

  function automatic logic [20:0] rand_code();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return 21'h0;
    if (pick < 40) return 21'(BYTE_SPACE);
    if (pick < 60) return 21'($urandom_range(1, 'h7F));
    if (pick < 70) return 21'($urandom_range('h80, 'h7FF));
    if (pick < 82) return 21'($urandom_range('h800, 'hFFFF));
    if (pick < 92) return 21'($urandom_range('h10000, 'h10FFFF));
    return 21'($urandom_range('h110000, 'h1FFFFF));
  endfunction

  task automatic send_cell(input logic [15:0] row, input logic [9:0] col,
                           input logic [10:0] wid, input logic [20:0] cp, input logic wide,
                           input logic wrap, input logic rend, input logic nocell);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    row_index <= row;
    column_index <= col;
    line_width <= wid;
    glyph_code <= cp;
    wide_half <= wide;
    row_wrapped <= wrap;
    row_end <= rend;
    no_cell <= nocell;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    cells_sent++;
  endtask

  task automatic send_noise();
    send_cell(16'($urandom), 10'($urandom), 11'($urandom), 21'($urandom), 1'($urandom),
              1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_row(input logic [15:0] row);
    logic [9:0]  cols[$];
    int unsigned wid;
    int unsigned span;
    int unsigned kind;
    logic        wrap;
    logic        last;
    kind = $urandom_range(99);
    if (kind < 80) wid = $urandom_range(0, 10);
    else if (kind < 90) wid = $urandom_range(1000, 1024);
    else wid = $urandom_range(1025, 2047);
    span = (wid > 1024) ? 1024 : wid;
    if (span <= 12) begin
      for (int c = 0; c < span; c++) cols.insert(cols.size(), 10'(c));
    end else begin
      repeat (4) cols.insert(cols.size(), 10'($urandom_range(0, span - 1)));
      cols.insert(cols.size(), 10'(span - 2));
      cols.insert(cols.size(), 10'(span - 1));
    end
    if (span < 1024 && $urandom_range(9) == 0)
      cols.insert(cols.size(), 10'($urandom_range(span, 1023)));
    wrap = ($urandom_range(3) == 0);
    kind = $urandom_range(99);
    if (cols.size() == 0 && kind < 75) kind = 80;
    foreach (cols[k]) begin
      last = (kind < 75) && (k == cols.size() - 1);
      send_cell(row, cols[k], 11'(wid), rand_code(), $urandom_range(6) == 0, wrap, last, 1'b0);
    end
    if (kind >= 75 && kind < 90) begin
      if ($urandom_range(3) == 0)
        send_cell(row, 10'($urandom), 11'(wid), 21'($urandom), 1'($urandom), wrap, 1'b0, 1'b1);
      send_cell(row, 10'($urandom), 11'(wid), 21'($urandom), 1'($urandom), wrap, 1'b1, 1'b1);
    end
  endtask

  task automatic run_rows(input int unsigned fr, input int unsigned lr, input int unsigned items);
    int unsigned start;
    int unsigned cur;
    int unsigned pick;
    start = cells_sent;
    cur = fr;
    while (cells_sent - start < items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_noise();
      end else if (pick < 13) begin
        if (lr < 65535) send_row(16'(lr + 1));
        else if (fr > 0) send_row(16'(fr - 1));
        else send_row(16'(cur));
      end else begin
        send_row(16'(cur));
        cur = (cur >= lr) ? fr : cur + 1;
      end
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (beats_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic set_selection(input logic act, input logic [15:0] fr, input logic [9:0] fc,
                               input logic [15:0] lr, input logic [9:0] lc);
    wait_idle();
    write_reg(REG_ACTIVE, {15'($urandom), act});
    write_reg(REG_FIRST_ROW, fr);
    write_reg(REG_FIRST_COL, {6'($urandom), fc});
    write_reg(REG_LAST_ROW, lr);
    write_reg(REG_LAST_COL, {6'($urandom), lc});
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pace(input int unsigned sender, input int unsigned receiver);
    send_idle_pct = sender;
    stall_pct <= receiver;
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned fr;
    int unsigned lr;
    logic [9:0]  fc;
    logic [9:0]  lc;
    fr = $urandom_range(0, 65535);
    lr = fr + $urandom_range(0, 3);
    if (lr > 65535) lr = 65535;
    fc = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
    lc = ($urandom_range(4) == 0) ? 10'd1023 : 10'($urandom_range(0, 9));
    set_selection(1'b1, 16'(fr), fc, 16'(lr), lc);
    run_rows(fr, lr, items);
  endtask

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    row_index <= '0;
    column_index <= '0;
    line_width <= '0;
    glyph_code <= '0;
    wide_half <= 1'b0;
    row_wrapped <= 1'b0;
    row_end <= 1'b0;
    no_cell <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ACTIVE;
    cfg_data <= '0;
    cells_sent = 0;
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_seq <= 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pace(0, 0);
    set_selection(1'b1, 16'd5, 10'd2, 16'd7, 10'd3);
    send_cell(16'd4, 10'd0, 11'd4, 21'h41, 1'b0, 1'b0, 1'b1, 1'b0);
    send_cell(16'd5, 10'd0, 11'd6, 21'h41, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd5, 10'd2, 11'd6, 21'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd5, 10'd3, 11'd6, 21'hE9, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd5, 10'd4, 11'd6, 21'h4E00, 1'b1, 1'b0, 1'b0, 1'b0);
    send_cell(16'd5, 10'd5, 11'd6, 21'h20, 1'b0, 1'b0, 1'b1, 1'b0);
    send_cell(16'd6, 10'd9, 11'd4, 21'h41, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd6, 10'd0, 11'd4, 21'h20AC, 1'b0, 1'b1, 1'b0, 1'b0);
    send_cell(16'd6, 10'd1, 11'd4, 21'hD800, 1'b0, 1'b1, 1'b0, 1'b0);
    send_cell(16'd6, 10'd2, 11'd4, 21'h10FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    send_cell(16'd6, 10'd3, 11'd4, 21'h1FFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    send_cell(16'd6, 10'd0, 11'd4, 21'h0, 1'b0, 1'b1, 1'b0, 1'b1);
    send_cell(16'd6, 10'd0, 11'd4, 21'h0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_cell(16'd6, 10'd1023, 11'd2047, 21'h7A, 1'b0, 1'b0, 1'b1, 1'b0);
    send_cell(16'd6, 10'd1023, 11'd1000, 21'h7A, 1'b0, 1'b0, 1'b1, 1'b0);
    send_cell(16'd7, 10'd0, 11'd8, 21'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd7, 10'd1, 11'd8, 21'h62, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd7, 10'd2, 11'd8, 21'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd7, 10'd5, 11'd8, 21'h63, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd7, 10'd3, 11'd8, 21'h0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_cell(16'd7, 10'd0, 11'd0, 21'h0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_cell(16'd8, 10'd0, 11'd4, 21'h41, 1'b0, 1'b0, 1'b1, 1'b0);
    send_cell(16'd6, 10'd0, 11'd3, 21'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd7, 10'd1, 11'd8, 21'h78, 1'b0, 1'b0, 1'b1, 1'b0);

    // An inactive selection and an inverted range must both stay silent.
    set_selection(1'b0, 16'd0, 10'd0, 16'd65535, 10'd1023);
    run_rows(0, 3, 4);
    set_selection(1'b1, 16'd9, 10'd0, 16'd3, 10'd1023);
    run_rows(9, 3, 4);

    // Blanks held across a row without a row end, flushed by one character.
    set_selection(1'b1, 16'd100, 10'd0, 16'd101, 10'd1023);
    for (int c = 0; c < 12; c++)
      send_cell(16'd100, 10'(c), 11'd1024, 21'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    for (int c = 0; c < 3; c++)
      send_cell(16'd101, 10'(c), 11'd1024, 21'h20, 1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(16'd101, 10'd3, 11'd1024, 21'h78, 1'b0, 1'b0, 1'b1, 1'b0);

    set_selection(1'b1, 16'd65535, 10'd1023, 16'd65535, 10'd1023);
    run_rows(65535, 65535, 8);
    set_selection(1'b1, 16'd0, 10'd0, 16'd65535, 10'd0);
    run_rows(0, 65535, 8);

    set_pace(0, 0);
    random_phase(18);
    set_pace(52, 0);
    random_phase(18);
    set_pace(0, 52);
    random_phase(18);
    set_pace(37, 37);
    random_phase(18);

    set_pace(0, 0);
    set_selection(1'b1, 16'd200, 10'd0, 16'd203, 10'd1023);
    hold_seq <= hold_seq + 1;
    run_rows(200, 203, 25);

    set_pace(37, 37);
    random_phase(8);
    wait_idle();

    if (fail_count == 0 && beats_due == 0) begin
      $display("selection_text_serializer_top_tb passed");
    end else begin
      $display("selection_text_serializer_top_tb failed");
    end
    $finish;
  end

endmodule
